// ===== rtl/acm_pkg.sv =====
// Shared types, register map and reset values for the alarm match and timeout block.
package acm_pkg;

	// Register map: word index taken from paddr[4:2]
	localparam int unsigned AddrWidth = 5;
	localparam int unsigned DataWidth = 32;

	typedef enum logic [2:0] {
		REG_ALARM_MINUTE = 3'd0,
		REG_ONE_TIME     = 3'd1,
		REG_WEEKDAY_MASK = 3'd2,
		REG_DATE_DAY     = 3'd3,
		REG_DATE_MONTH   = 3'd4,
		REG_DATE_YEAR    = 3'd5,
		REG_MAX_SECONDS  = 3'd6,
		REG_UNUSED       = 3'd7
	} reg_idx_t;

	// Reset values of the configuration registers
	localparam logic signed [11:0] RstAlarmMinute = -12'sd1;
	localparam logic        RstOneTime     = 1'b0;
	localparam logic [6:0]  RstWeekdayMask = 7'd0;
	localparam logic [4:0]  RstDateDay     = 5'd1;
	localparam logic [3:0]  RstDateMonth   = 4'd1;
	localparam logic [13:0] RstDateYear    = 14'd2000;
	localparam logic [15:0] RstMaxSeconds  = 16'd300;

	// Minutes per hour
	localparam logic [5:0] MinPerHour = 6'd60;

	typedef struct packed {
		logic signed [11:0] alarm_minute;
		logic               one_time;
		logic [6:0]         weekday_mask;
		logic [4:0]         date_day;
		logic [3:0]         date_month;
		logic [13:0]        date_year;
		logic [15:0]        max_seconds;
	} cfg_t;

	typedef struct packed {
		logic [31:0] now_seconds;
		logic [2:0]  weekday;
		logic [4:0]  day_of_month;
		logic [3:0]  month;
		logic [13:0] year;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic        motion;
	} item_t;

	typedef struct packed {
		logic        buzzer;
		logic        stopped;
		logic        timed_out;
		logic [31:0] duration_seconds;
		logic [2:0]  start_weekday;
	} result_t;

endpackage

// ===== rtl/acm_cfg.sv =====
// APB register file holding the alarm settings.
module acm_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [acm_pkg::AddrWidth-1:0]      paddr,
	input  logic [acm_pkg::DataWidth-1:0]      pwdata,
	output logic [acm_pkg::DataWidth-1:0]      prdata,
	output logic                               pready,
	output acm_pkg::cfg_t                      cfg
);

	acm_pkg::cfg_t    cfg_q;
	acm_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx    = acm_pkg::reg_idx_t'(paddr[acm_pkg::AddrWidth-1:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	// Write the addressed register on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alarm_minute <= acm_pkg::RstAlarmMinute;
			cfg_q.one_time     <= acm_pkg::RstOneTime;
			cfg_q.weekday_mask <= acm_pkg::RstWeekdayMask;
			cfg_q.date_day     <= acm_pkg::RstDateDay;
			cfg_q.date_month   <= acm_pkg::RstDateMonth;
			cfg_q.date_year    <= acm_pkg::RstDateYear;
			cfg_q.max_seconds  <= acm_pkg::RstMaxSeconds;
		end else if (wr_en) begin
			case (idx)
				acm_pkg::REG_ALARM_MINUTE: cfg_q.alarm_minute <= pwdata[11:0];
				acm_pkg::REG_ONE_TIME:     cfg_q.one_time     <= pwdata[0];
				acm_pkg::REG_WEEKDAY_MASK: cfg_q.weekday_mask <= pwdata[6:0];
				acm_pkg::REG_DATE_DAY:     cfg_q.date_day     <= pwdata[4:0];
				acm_pkg::REG_DATE_MONTH:   cfg_q.date_month   <= pwdata[3:0];
				acm_pkg::REG_DATE_YEAR:    cfg_q.date_year    <= pwdata[13:0];
				acm_pkg::REG_MAX_SECONDS:  cfg_q.max_seconds  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Return the addressed register, zero-extended
	always_comb begin
		case (idx)
			acm_pkg::REG_ALARM_MINUTE: prdata = {20'd0, cfg_q.alarm_minute};
			acm_pkg::REG_ONE_TIME:     prdata = {31'd0, cfg_q.one_time};
			acm_pkg::REG_WEEKDAY_MASK: prdata = {25'd0, cfg_q.weekday_mask};
			acm_pkg::REG_DATE_DAY:     prdata = {27'd0, cfg_q.date_day};
			acm_pkg::REG_DATE_MONTH:   prdata = {28'd0, cfg_q.date_month};
			acm_pkg::REG_DATE_YEAR:    prdata = {18'd0, cfg_q.date_year};
			acm_pkg::REG_MAX_SECONDS:  prdata = {16'd0, cfg_q.max_seconds};
			default:                   prdata = '0;
		endcase
	end

endmodule

// ===== rtl/acm_core.sv =====
// Input register, alarm evaluation, ring state and result register.
module acm_core (
	input  logic             clk,
	input  logic             arst_n,
	input  acm_pkg::cfg_t    cfg,
	input  logic             item_valid,
	output logic             item_stall,
	input  acm_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output acm_pkg::result_t result
);

	logic             valid_s1;
	acm_pkg::item_t   item_s1;
	logic             out_valid_q;
	acm_pkg::result_t out_q;

	logic             ringing_q;
	logic [31:0]      start_seconds_q;
	logic [2:0]       start_day_q;

	logic             out_free;
	logic             advance;
	logic             due;
	logic [7:0]       mask_ext;
	logic [10:0]      cur_minute;
	logic             start_hit;
	logic [31:0]      elapsed;
	logic             limit;
	acm_pkg::result_t res_next;

	// Result slot frees when empty or when its word is taken
	assign out_free   = !out_valid_q || !result_stall;
	assign advance    = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	// Decide whether the alarm is due today
	assign mask_ext = {1'b0, cfg.weekday_mask};
	always_comb begin
		if (cfg.one_time) begin
			due = (item_s1.day_of_month == cfg.date_day) &&
			      (item_s1.month == cfg.date_month) &&
			      (item_s1.year == cfg.date_year);
		end else begin
			due = mask_ext[item_s1.weekday];
		end
	end

	// Minute of day against the programmed start, sign bit blocks a match
	assign cur_minute = 11'(item_s1.hour * acm_pkg::MinPerHour) + 11'(item_s1.minute);
	assign start_hit  = ({1'b0, cur_minute} == cfg.alarm_minute) && (item_s1.second <= 6'd1);

	// Elapsed ring time, modulo the counter width
	assign elapsed = item_s1.now_seconds - start_seconds_q;
	assign limit   = elapsed >= {16'd0, cfg.max_seconds};

	// Form the result word
	always_comb begin
		res_next = '0;
		if (due) begin
			if (ringing_q) begin
				if (limit || item_s1.motion) begin
					res_next.stopped          = 1'b1;
					res_next.timed_out        = limit;
					res_next.duration_seconds = elapsed;
					res_next.start_weekday    = start_day_q;
				end else begin
					res_next.buzzer = 1'b1;
				end
			end else if (start_hit) begin
				res_next.buzzer = 1'b1;
			end
		end
	end

	// Advance ring state as each word leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ringing_q       <= 1'b0;
			start_seconds_q <= '0;
			start_day_q     <= '0;
		end else if (advance && due) begin
			if (ringing_q) begin
				if (limit || item_s1.motion) begin
					ringing_q <= 1'b0;
				end
			end else if (start_hit) begin
				ringing_q       <= 1'b1;
				start_seconds_q <= item_s1.now_seconds;
				start_day_q     <= item_s1.weekday;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res_next;
		end
	end

endmodule

// ===== rtl/alarm_match_and_timeout_top.sv =====
// Top level of the alarm match and timeout block.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+--------------------------
//  item      | item_valid / item_stall    | item   (acm_pkg::item_t)
//  result    | result_valid / result_stall| result (acm_pkg::result_t)
//  config    | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One word in, one word out; a word is accepted every cycle while results drain.
// Each word passes the input register, then the result register.
// Ring state updates as a word moves into the result register.
// A stalled result holds the result register and, once the input register is full,
// stalls the input. Reset clears control and loads register defaults.
module alarm_match_and_timeout_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  acm_pkg::item_t                     item,
	output logic                               result_valid,
	input  logic                               result_stall,
	output acm_pkg::result_t                   result,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [acm_pkg::AddrWidth-1:0]      paddr,
	input  logic [acm_pkg::DataWidth-1:0]      pwdata,
	output logic [acm_pkg::DataWidth-1:0]      prdata,
	output logic                               pready
);

	acm_pkg::cfg_t cfg;

	acm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	acm_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
